FILE: rtl/stf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sparse triplet fast transpose block.
// No dependencies; used by the core, the checker and the bench.
package stf_pkg;

    localparam int MAX_TERMS_DEF = 32;
    localparam int MAX_DIM_DEF   = 256;

    localparam int IDX_W = 8;   // entry row / column index
    localparam int DIM_W = 9;   // dimension registers and output indexes
    localparam int VAL_W = 32;
    localparam int ENT_W = 2 * IDX_W + VAL_W;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    // configuration register indexes
    localparam logic [0:0] CFG_NUM_ROWS = 1'b0;
    localparam logic [0:0] CFG_NUM_COLS = 1'b1;

    typedef struct packed {
        logic                    has_entry;
        logic [IDX_W-1:0]        entry_row;
        logic [IDX_W-1:0]        entry_col;
        logic signed [VAL_W-1:0] entry_value;
        logic                    last_entry;
    } t_in_beat;

    typedef struct packed {
        logic                    is_header;
        logic [DIM_W-1:0]        out_row;
        logic [DIM_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    out_last;
    } t_out_beat;

    typedef struct packed {
        logic [0:0]       reg_index;
        logic [DIM_W-1:0] reg_value;
    } t_cfg_beat;

endpackage

FILE: rtl/stf_chan.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload beat of type T.
// No dependencies; the payload types come from stf_pkg at instantiation.
interface stf_chan #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/stf_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/sparse_triplet_fast_transpose.sv
`timescale 1ns / 1ps
// Sparse matrix fast transpose over a stream of (row, col, value) triplets.
//
// Channels: i_in takes one triplet beat per item; last_entry closes the matrix.
// o_out gives the transposed list: a header beat (column count, row count, term
// count), then the swapped triplets in column order, stable within a column,
// with out_last on the final beat. i_cfg writes the row count (index 0) and the
// column count (index 1); it is always ready and must be used only while idle;
// the block does not enforce this. A stored entry does a read-modify-write of
// its column counter in the count RAM; a beat without one leaves it untouched.
// The last item then runs a prefix walk over the count RAM, a scatter per term
// (entry read, start read, write), and emits the header and then each term
// (transposed store read, then load).
// Columns out of range and entries beyond MAX_TERMS are dropped.
// The result sits in an output register: a stalled receiver only holds the
// emit sequence, and the next matrix can load while the final beat waits.
// Reset (synchronous, active low) clears the term count, the column counter
// valid bits and the output valid flag; the registers return to 256. The
// entry stores need no clearing.
// Depends on stf_pkg, stf_chan and stf_ram.
module sparse_triplet_fast_transpose
    import stf_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int MAX_DIM   = MAX_DIM_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    stf_chan.sink   i_in,
    stf_chan.source o_out,
    stf_chan.sink   i_cfg
);
    localparam int CW  = $clog2(MAX_TERMS + 1);
    localparam int TAW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int DW  = $clog2(MAX_DIM);

    typedef enum logic [3:0] {
        S_IDLE, S_INC, S_PFX, S_PFXW, S_SRD, S_SCOL, S_SWR, S_HDR, S_ORD, S_OWT
    } t_state;

    t_state           r_state;
    logic [DIM_W-1:0] r_num_rows;
    logic [DIM_W-1:0] r_cols_cfg;
    logic [CW-1:0]    r_terms;
    logic [CW-1:0]    r_k;
    logic [CW-1:0]    r_pos;
    logic [DW-1:0]    r_col;
    logic [DW-1:0]    r_idx;
    logic [DW-1:0]    r_pidx;
    logic             r_pv;
    logic             r_last;
    logic             r_rvld;
    logic [MAX_DIM-1:0] r_cnt_vld;
    logic             r_ov;
    t_out_beat        r_out;

    // RAM controls
    logic             e_we, e_re, t_we, t_re, c_we, c_re;
    logic [TAW-1:0]   e_waddr, e_raddr, t_waddr, t_raddr;
    logic [ENT_W-1:0] e_wdata, e_rdata, t_wdata, t_rdata;
    logic [DW-1:0]    c_waddr, c_raddr;
    logic [CW-1:0]    c_wdata, c_rdata, cnt_eff;

    logic             in_acc, in_ok, out_free, out_load, emit_last;
    logic [IDX_W-1:0] e_col;
    logic [DW-1:0]    e_col_idx;
    t_out_beat        n_out;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    assign in_acc   = i_in.valid && i_in.ready;
    assign in_ok    = i_in.data.has_entry
                      && ({1'b0, i_in.data.entry_col} < r_cols_cfg)
                      && ({1'b0, i_in.data.entry_col} < DIM_W'(MAX_DIM))
                      && (r_terms < CW'(MAX_TERMS));
    assign out_free = !r_ov || o_out.ready;
    assign out_load = out_free && ((r_state == S_HDR) || (r_state == S_OWT));

    // unwritten column counters read as zero
    assign cnt_eff   = r_rvld ? c_rdata : '0;
    assign e_col     = e_rdata[VAL_W +: IDX_W];
    assign e_col_idx = e_col[DW-1:0];
    assign emit_last = ((r_k + CW'(1)) == r_terms);

    always_comb begin
        e_we    = (r_state == S_IDLE) && in_acc && in_ok;
        e_waddr = r_terms[TAW-1:0];
        e_wdata = {i_in.data.entry_row, i_in.data.entry_col, i_in.data.entry_value};
        e_re    = (r_state == S_SRD);
        e_raddr = r_k[TAW-1:0];
        t_we    = (r_state == S_SWR);
        t_waddr = cnt_eff[TAW-1:0];
        // swapped: column becomes row
        t_wdata = {e_col, e_rdata[VAL_W + IDX_W +: IDX_W], e_rdata[VAL_W-1:0]};
        t_re    = (r_state == S_ORD);
        t_raddr = r_k[TAW-1:0];

        c_we    = 1'b0;
        c_waddr = r_pidx;
        c_wdata = r_pos;
        c_re    = 1'b0;
        c_raddr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                c_re    = in_acc && in_ok;
                c_raddr = i_in.data.entry_col[DW-1:0];
            end
            S_INC: begin
                c_we    = 1'b1;
                c_waddr = r_col;
                c_wdata = cnt_eff + CW'(1);
            end
            S_PFX: begin
                c_re = 1'b1;
                c_we = r_pv;
            end
            S_PFXW: begin
                c_we = 1'b1;
            end
            S_SCOL: begin
                c_re    = 1'b1;
                c_raddr = e_col_idx;
            end
            S_SWR: begin
                c_we    = 1'b1;
                c_waddr = e_col_idx;
                c_wdata = cnt_eff + CW'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out = '0;
        if (r_state == S_HDR) begin
            n_out.is_header = 1'b1;
            n_out.out_row   = r_cols_cfg;
            n_out.out_col   = r_num_rows;
            n_out.out_value = VAL_W'(r_terms);
            n_out.out_last  = (r_terms == '0);
        end else begin
            n_out.out_row   = {1'b0, t_rdata[VAL_W + IDX_W +: IDX_W]};
            n_out.out_col   = {1'b0, t_rdata[VAL_W +: IDX_W]};
            n_out.out_value = $signed(t_rdata[VAL_W-1:0]);
            n_out.out_last  = emit_last;
        end
    end

    stf_ram #(.WIDTH(ENT_W), .DEPTH(MAX_TERMS), .AW(TAW)) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (e_we),
        .i_waddr(e_waddr),
        .i_wdata(e_wdata),
        .i_re   (e_re),
        .i_raddr(e_raddr),
        .o_rdata(e_rdata)
    );

    stf_ram #(.WIDTH(ENT_W), .DEPTH(MAX_TERMS), .AW(TAW)) u_trans_ram (
        .i_clk  (i_clk),
        .i_we   (t_we),
        .i_waddr(t_waddr),
        .i_wdata(t_wdata),
        .i_re   (t_re),
        .i_raddr(t_raddr),
        .o_rdata(t_rdata)
    );

    // column counters, rewritten in place as start positions
    stf_ram #(.WIDTH(CW), .DEPTH(MAX_DIM), .AW(DW)) u_count_ram (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(c_waddr),
        .i_wdata(c_wdata),
        .i_re   (c_re),
        .i_raddr(c_raddr),
        .o_rdata(c_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_num_rows <= DIM_RESET;
            r_cols_cfg <= DIM_RESET;
            r_terms    <= '0;
            r_cnt_vld  <= '0;
            r_ov       <= 1'b0;
            r_pv       <= 1'b0;
            r_rvld     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.data.reg_index)
                    CFG_NUM_ROWS: r_num_rows <= i_cfg.data.reg_value;
                    CFG_NUM_COLS: r_cols_cfg <= i_cfg.data.reg_value;
                    default:      r_cols_cfg <= i_cfg.data.reg_value;
                endcase
            end
            if (out_load) begin
                r_ov  <= 1'b1;
                r_out <= n_out;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (c_re) begin
                r_rvld <= r_cnt_vld[c_raddr];
            end
            if (c_we) begin
                r_cnt_vld[c_waddr] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_col  <= i_in.data.entry_col[DW-1:0];
                        r_last <= i_in.data.last_entry;
                        r_idx  <= '0;
                        r_pv   <= 1'b0;
                        r_pos  <= '0;
                        if (in_ok) begin
                            r_state <= S_INC;
                        end else if (i_in.data.last_entry) begin
                            r_state <= S_PFX;
                        end
                    end
                end
                S_INC: begin
                    r_terms <= r_terms + CW'(1);
                    r_state <= r_last ? S_PFX : S_IDLE;
                end
                S_PFX: begin
                    if (r_pv) begin
                        r_pos <= r_pos + cnt_eff;
                    end
                    r_pidx <= r_idx;
                    r_pv   <= 1'b1;
                    r_idx  <= r_idx + DW'(1);
                    if (r_idx == DW'(MAX_DIM - 1)) begin
                        r_state <= S_PFXW;
                    end
                end
                S_PFXW: begin
                    r_k     <= '0;
                    r_state <= (r_terms == '0) ? S_HDR : S_SRD;
                end
                S_SRD:  r_state <= S_SCOL;
                S_SCOL: r_state <= S_SWR;
                S_SWR: begin
                    if (emit_last) begin
                        r_k     <= '0;
                        r_state <= S_HDR;
                    end else begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_SRD;
                    end
                end
                S_HDR: begin
                    if (out_free) begin
                        if (r_terms == '0) begin
                            r_cnt_vld <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_state <= S_ORD;
                        end
                    end
                end
                S_ORD: r_state <= S_OWT;
                S_OWT: begin
                    if (out_free) begin
                        r_k <= r_k + CW'(1);
                        if (emit_last) begin
                            r_cnt_vld <= '0;
                            r_terms   <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/stf_chk.sv
`timescale 1ns / 1ps
// Port-level checks for sparse_triplet_fast_transpose, bound to the top level.
// Depends on stf_pkg for the output beat type.
module stf_chk
    import stf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_beat i_out_data
);
    logic out_acc;
    assign out_acc = i_out_valid && i_out_ready;

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result beat dropped or changed while stalled");

    // no new item while a list is still being emitted
    a_no_in_mid_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.out_last |-> !i_in_ready)
        else $error("input ready in the middle of a list");

    // a header never follows a non-final beat
    a_no_hdr_mid_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !i_out_data.out_last |=> !(i_out_valid && i_out_data.is_header))
        else $error("header inside a list");

    // header and last agree only for an empty list
    a_hdr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.is_header && i_out_data.out_last
            |-> i_out_data.out_value == '0)
        else $error("header marked last with nonzero term count");
endmodule

bind sparse_triplet_fast_transpose stf_chk u_stf_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_data (o_out.data)
);

FILE: sim/tb_sparse_triplet_fast_transpose.sv
`timescale 1ns / 1ps
// Self-checking bench for sparse_triplet_fast_transpose: streams triplet matrices,
// predicts each transposed list in a scoreboard class and checks every output beat.
// Depends on stf_pkg, stf_chan and the block itself.
module tb_sparse_triplet_fast_transpose;
    import stf_pkg::*;

    localparam int SETTLE_CYCLES = 400;     // prefix walk + scatter + slack
    localparam int HOLD_CYCLES   = 1500;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 35;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    class transpose_scoreboard;
        logic [DIM_W-1:0] rows_reg = DIM_RESET;
        logic [DIM_W-1:0] cols_reg = DIM_RESET;
        t_in_beat  held[$];
        t_out_beat list_out[$];
        int        mismatches = 0;

        function void write_reg(t_cfg_beat c);
            if (c.reg_index == CFG_NUM_ROWS)
                rows_reg = c.reg_value;
            else
                cols_reg = c.reg_value;
        endfunction

        function void note_input(t_in_beat b);
            t_out_beat beat;
            int        n;
            int        emitted;
            if (b.has_entry && {1'b0, b.entry_col} < cols_reg
                && held.size() < MAX_TERMS_DEF)
                held.push_back(b);
            if (!b.last_entry)
                return;
            n = held.size();
            beat.is_header = 1'b1;
            beat.out_row   = cols_reg;
            beat.out_col   = rows_reg;
            beat.out_value = n;
            beat.out_last  = (n == 0);
            list_out.push_back(beat);
            // stable counting order: walk columns, keep arrival order inside each
            emitted = 0;
            for (int c = 0; c < MAX_DIM_DEF; c++) begin
                foreach (held[k]) begin
                    if (held[k].entry_col == c) begin
                        emitted++;
                        beat.is_header = 1'b0;
                        beat.out_row   = DIM_W'(c);
                        beat.out_col   = {1'b0, held[k].entry_row};
                        beat.out_value = held[k].entry_value;
                        beat.out_last  = (emitted == n);
                        list_out.push_back(beat);
                    end
                end
            end
            held.delete();
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            if (list_out.size() == 0) begin
                if (mismatches < 10)
                    $display({"ERROR: beat with nothing expected: ",
                              "hdr=%0d row=%0d col=%0d val=%0d last=%0d"},
                             got.is_header, got.out_row, got.out_col, got.out_value,
                             got.out_last);
                mismatches++;
                return;
            end
            want = list_out.pop_front();
            if (got.is_header !== want.is_header || got.out_row !== want.out_row ||
                got.out_col !== want.out_col || got.out_value !== want.out_value ||
                got.out_last !== want.out_last) begin
                if (mismatches < 10)
                    $display({"ERROR: beat mismatch: ",
                              "exp hdr=%0d row=%0d col=%0d val=%0d last=%0d | ",
                              "got hdr=%0d row=%0d col=%0d val=%0d last=%0d"},
                             want.is_header, want.out_row, want.out_col, want.out_value,
                             want.out_last, got.is_header, got.out_row, got.out_col,
                             got.out_value, got.out_last);
                mismatches++;
            end
        endfunction

        function int pending();
            return list_out.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    t_idle_mode idle_mode;
    logic       pressure_req;
    logic       pressure_taken = 1'b0;
    int         hold_left = 0;
    int         items_sent = 0;
    int         cycles = 0;

    transpose_scoreboard sb = new;

    stf_chan #(.T(t_in_beat))  in_ch  ();
    stf_chan #(.T(t_out_beat)) out_ch ();
    stf_chan #(.T(t_cfg_beat)) cfg_ch ();

    sparse_triplet_fast_transpose u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    function automatic int stall_pct();
        case (idle_mode)
            IDLE_RECV: return 50;
            IDLE_BOTH: return 28;
            default:   return 0;
        endcase
    endfunction

    function automatic int gap_pct();
        case (idle_mode)
            IDLE_SEND: return 50;
            IDLE_BOTH: return 28;
            default:   return 0;
        endcase
    endfunction

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_sparse_triplet_fast_transpose failed");
            $finish;
        end
    end

    // beat monitor: everything sampled as it stood before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                sb.note_input(in_ch.data);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.data);
        end
    end

    // receiver: random stalls per mode, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (pressure_req && !pressure_taken) begin
            hold_left = HOLD_CYCLES;
            pressure_taken = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct());
        end
    end

    function automatic t_in_beat mk_item(logic has, logic [7:0] row, logic [7:0] col,
                                         logic [31:0] value, logic last);
        t_in_beat b;
        b.has_entry   = has;
        b.entry_row   = row;
        b.entry_col   = col;
        b.entry_value = value;
        b.last_entry  = last;
        return b;
    endfunction

    function automatic logic [7:0] pick_col(int lim);
        int r;
        r = $urandom_range(0, 9);
        if (lim == 0 || r < 2)
            return 8'($urandom_range(0, 255));
        if (r < 5)
            return 8'($urandom_range(0, (lim < 4) ? lim - 1 : 3));   // crowd a few columns
        return 8'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return 9'd1;
            1:       return DIM_RESET;
            2:       return 9'd0;
            3:       return 9'h1FF;
            4, 5, 6: return 9'($urandom_range(1, 8));
            default: return 9'($urandom_range(1, 256));
        endcase
    endfunction

    // valid stays high after acceptance so back-to-back beats need no re-raise
    task automatic send_item(t_in_beat b);
        while ($urandom_range(0, 99) < gap_pct()) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (b.has_entry || b.last_entry)
            items_sent++;
    endtask

    task automatic send_matrix(int n_entries);
        t_in_beat b;
        int       lim;
        for (int k = 0; k <= n_entries; k++) begin
            lim = (sb.cols_reg > 9'd256) ? 256 : int'(sb.cols_reg);
            b.has_entry   = (k == n_entries) ? 1'($urandom_range(0, 1))
                                             : ($urandom_range(0, 9) != 0);
            b.entry_row   = 8'($urandom);
            b.entry_col   = pick_col(lim);
            b.entry_value = pick_value();
            b.last_entry  = (k == n_entries);
            send_item(b);
        end
    endtask

    task automatic write_reg(logic [0:0] idx, logic [DIM_W-1:0] value);
        t_cfg_beat c;
        c.reg_index = idx;
        c.reg_value = value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= c;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // first edge lets the monitor log the final input beat before pending() is read
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int n;
        int phase_start;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        idle_mode    = IDLE_NONE;
        pressure_req = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, stable order within a column, idle beat, header-only lists
        send_item(mk_item(1'b1, 8'd0,   8'd0,   32'h8000_0000, 1'b0));
        send_item(mk_item(1'b1, 8'd255, 8'd255, 32'h7FFF_FFFF, 1'b0));
        send_item(mk_item(1'b1, 8'd7,   8'd0,   32'd5,         1'b0));
        send_item(mk_item(1'b0, 8'hFF,  8'hFF,  32'hFFFF_FFFF, 1'b0));
        send_item(mk_item(1'b1, 8'd3,   8'd128, 32'hFFFF_FFFF, 1'b1));
        send_item(mk_item(1'b0, 8'd0,   8'd0,   32'd0,         1'b1));
        send_item(mk_item(1'b1, 8'd1,   8'd2,   32'd0,         1'b1));
        settle();
        write_reg(CFG_NUM_ROWS, 9'd1);
        write_reg(CFG_NUM_COLS, 9'd4);
        // column at and past the limit gets dropped; row is not range checked
        send_item(mk_item(1'b1, 8'd200, 8'd3,   32'd1,         1'b0));
        send_item(mk_item(1'b1, 8'd9,   8'd4,   32'd2,         1'b0));
        send_item(mk_item(1'b1, 8'd9,   8'd255, 32'd3,         1'b0));
        send_item(mk_item(1'b0, 8'd0,   8'd0,   32'd0,         1'b1));
        settle();
        write_reg(CFG_NUM_ROWS, 9'd0);
        write_reg(CFG_NUM_COLS, 9'd0);
        send_item(mk_item(1'b1, 8'd5,   8'd0,   32'd9,         1'b1));
        settle();
        write_reg(CFG_NUM_ROWS, 9'h1FF);
        write_reg(CFG_NUM_COLS, 9'h1FF);
        send_item(mk_item(1'b1, 8'd255, 8'd255, 32'h1234_5678, 1'b1));
        settle();
        write_reg(CFG_NUM_ROWS, DIM_RESET);
        write_reg(CFG_NUM_COLS, DIM_RESET);
        // store overflow: 35 beats, most of them entries, past the 32-entry store
        send_matrix(34);

        for (int p = 0; p < 4; p++) begin
            idle_mode   = t_idle_mode'(p);
            phase_start = items_sent;
            if (p == 0) begin
                // output held off while matrices keep coming; input must back up
                pressure_req = 1'b1;
                send_matrix(3);
                send_matrix(3);
                send_matrix(2);
            end
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0) begin
                    settle();
                    write_reg(CFG_NUM_ROWS, pick_dim());
                    write_reg(CFG_NUM_COLS, pick_dim());
                end
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40)
                                                : $urandom_range(0, 8);
                send_matrix(n);
            end
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_sparse_triplet_fast_transpose passed");
        else
            $display("tb_sparse_triplet_fast_transpose failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/stf_pkg.sv
rtl/stf_chan.sv
rtl/stf_ram.sv
rtl/sparse_triplet_fast_transpose.sv
rtl/stf_chk.sv
sim/tb_sparse_triplet_fast_transpose.sv
